@@ hdl/motor_feedback_unwrap_watchdog_defines.svh @@
// assertion macros for the motor feedback unwrap watchdog
`ifndef MOTOR_FEEDBACK_UNWRAP_WATCHDOG_DEFINES_SVH
`define MOTOR_FEEDBACK_UNWRAP_WATCHDOG_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MFUW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfuw same-cycle check failed");

// next-cycle implication, checked outside reset
`define MFUW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfuw next-cycle check failed");

`endif

@@ hdl/mfuw_pkg.sv @@
// shared types and constants for the motor feedback unwrap watchdog
package mfuw_pkg;

   localparam int POS_W   = 13;
   localparam int SPD_W   = 16;
   localparam int CUR_W   = 16;
   localparam int TEMP_W  = 8;
   localparam int TURN_W  = 32;
   localparam int ANGLE_W = 48;
   localparam int WD_W    = 16;
   localparam int FRAME_W = 64;
   localparam int DIFF_W  = POS_W + 2;

   localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(4096);
   localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(8192);
   localparam logic [WD_W-1:0] TIMEOUT_RESET = WD_W'(300);

   // request kinds carried on tuser
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // result word layout, lowest field first
   localparam int RSP_POS_LO    = 0;
   localparam int RSP_SPD_LO    = RSP_POS_LO + POS_W;
   localparam int RSP_CUR_LO    = RSP_SPD_LO + SPD_W;
   localparam int RSP_TEMP_LO   = RSP_CUR_LO + CUR_W;
   localparam int RSP_TURN_LO   = RSP_TEMP_LO + TEMP_W;
   localparam int RSP_ANGLE_LO  = RSP_TURN_LO + TURN_W;
   localparam int RSP_ONLINE    = RSP_ANGLE_LO + ANGLE_W;
   localparam int RSP_EVENT     = RSP_ONLINE + 1;
   localparam int RSP_USED_W    = RSP_EVENT + 1;
   localparam int RSP_W         = ((RSP_USED_W + 7) / 8) * 8;

   typedef struct packed {
      logic [POS_W-1:0]          last_position;
      logic signed [SPD_W-1:0]   speed;
      logic signed [CUR_W-1:0]   current;
      logic [TEMP_W-1:0]         temperature;
      logic signed [TURN_W-1:0]  turns;
      logic signed [ANGLE_W-1:0] angle;
      logic [WD_W-1:0]           watchdog;
      logic                      online;
   } state_type;

endpackage

@@ hdl/mfuw_step.sv @@
// next-state logic for one frame or tick: position unwrap and offline watchdog
module mfuw_step (
   input  logic                           cmd,
   input  logic [mfuw_pkg::FRAME_W-1:0]   frame_data,
   input  logic [mfuw_pkg::WD_W-1:0]      timeout_ticks,
   input  mfuw_pkg::state_type            state,
   output mfuw_pkg::state_type            state_next,
   output logic                           offline_event
);
   import mfuw_pkg::*;

   logic [POS_W-1:0]          pos;
   logic signed [DIFF_W-1:0]  diff_raw;
   logic signed [DIFF_W-1:0]  diff_adj;
   logic signed [TURN_W-1:0]  turns_adj;

   assign pos      = frame_data[48 +: POS_W];
   assign diff_raw = $signed({2'b00, pos}) - $signed({2'b00, state.last_position});

   // a step of exactly half a turn is taken as it is
   always_comb begin
      diff_adj  = diff_raw;
      turns_adj = state.turns;
      if (diff_raw > HALF_TURN) begin
         diff_adj  = diff_raw - FULL_TURN;
         turns_adj = state.turns - TURN_W'(1);
      end else if (diff_raw < -HALF_TURN) begin
         diff_adj  = diff_raw + FULL_TURN;
         turns_adj = state.turns + TURN_W'(1);
      end
   end

   always_comb begin
      state_next    = state;
      offline_event = 1'b0;
      if (cmd == CMD_FRAME) begin
         state_next.last_position = pos;
         state_next.speed         = frame_data[32 +: SPD_W];
         state_next.current       = frame_data[16 +: CUR_W];
         state_next.temperature   = frame_data[8 +: TEMP_W];
         state_next.turns         = turns_adj;
         state_next.angle         = state.angle
                                    + {{(ANGLE_W-DIFF_W){diff_adj[DIFF_W-1]}}, diff_adj};
         state_next.watchdog      = timeout_ticks;
         state_next.online        = 1'b1;
      end else if (state.online) begin
         // a zero timeout expires on the first tick as well
         if (state.watchdog <= WD_W'(1)) begin
            state_next.watchdog = '0;
            state_next.speed    = '0;
            state_next.current  = '0;
            state_next.online   = 1'b0;
            offline_event       = 1'b1;
         end else begin
            state_next.watchdog = state.watchdog - WD_W'(1);
         end
      end
   end

endmodule

@@ hdl/motor_feedback_unwrap_watchdog.sv @@
// top level: request register, unwrap/watchdog state and result register
//
//  channel  direction  payload                                         handshake
//  req      in         tdata = frame_data[63:0], tuser = cmd           tvalid/tready
//  rsp      out        tdata = 135 result bits + 1 pad bit             tvalid/tready
//  csr      in         csr_data = timeout_ticks[15:0]                  csr_valid/csr_ready
//
//  one request per cycle unless rsp stalls; request register, then result register
//  state registers loop to themselves through mfuw_step, which reads the request register
//  synchronous active-high reset: timeout 300, watchdog 300, online set, other state zero
//  a stalled rsp holds the result register and the request register behind it;
//  req_tready drops only when both are full
module motor_feedback_unwrap_watchdog (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // frame_data[63:0]
   input  logic [mfuw_pkg::FRAME_W-1:0]  req_tdata,
   // cmd
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // encoder_position[12:0], speed_rpm[28:13], torque_current[44:29],
   // temperature[52:45], turn_count[84:53], total_counts[132:85],
   // online[133], offline_event[134], zero[135]
   output logic [mfuw_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mfuw_pkg::WD_W-1:0]     csr_data
);
   import mfuw_pkg::*;

   `include "motor_feedback_unwrap_watchdog_defines.svh"

   logic                  req_valid_ff;
   logic                  req_cmd_ff;
   logic [FRAME_W-1:0]    req_data_ff;
   state_type             state_ff;
   state_type             state_in;
   logic [WD_W-1:0]       timeout_ff;
   logic                  rsp_valid_ff;
   logic [RSP_W-1:0]      rsp_data_ff;
   logic [RSP_W-1:0]      rsp_data_in;
   logic                  event_in;
   logic                  advance;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   mfuw_step u_step (
      .cmd           (req_cmd_ff),
      .frame_data    (req_data_ff),
      .timeout_ticks (timeout_ff),
      .state         (state_ff),
      .state_next    (state_in),
      .offline_event (event_in)
   );

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_POS_LO +: POS_W]     = state_in.last_position;
      rsp_data_in[RSP_SPD_LO +: SPD_W]     = state_in.speed;
      rsp_data_in[RSP_CUR_LO +: CUR_W]     = state_in.current;
      rsp_data_in[RSP_TEMP_LO +: TEMP_W]   = state_in.temperature;
      rsp_data_in[RSP_TURN_LO +: TURN_W]   = state_in.turns;
      rsp_data_in[RSP_ANGLE_LO +: ANGLE_W] = state_in.angle;
      rsp_data_in[RSP_ONLINE]              = state_in.online;
      rsp_data_in[RSP_EVENT]               = event_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff            <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         timeout_ff              <= TIMEOUT_RESET;
         state_ff                <= '{last_position: '0, speed: '0, current: '0,
                                      temperature: '0, turns: '0, angle: '0,
                                      watchdog: TIMEOUT_RESET, online: 1'b1};
      end else begin
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_cmd_ff  <= req_tuser;
         req_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // an offline event is never reported together with online
   `MFUW_ASSERT_NOW(a_event_offline, clock, reset,
                    rsp_valid_ff && rsp_data_ff[RSP_EVENT], !state_ff.online)
   // offline means the watchdog has run down
   `MFUW_ASSERT_NOW(a_offline_wd_zero, clock, reset,
                    !state_ff.online, state_ff.watchdog == '0)
   // offline zeroes speed and current
   `MFUW_ASSERT_NOW(a_offline_zeroed, clock, reset,
                    !state_ff.online, state_ff.speed == '0 && state_ff.current == '0)
   // a stalled request keeps its place and contents
   `MFUW_ASSERT_NEXT(a_req_hold, clock, reset,
                     req_valid_ff && !advance, req_valid_ff && $stable(req_data_ff))

endmodule

@@ test/mfuw_feedback_checker.sv @@
`timescale 1ns / 100ps
// feedback checker: predicts unwrap/watchdog results from accepted requests and compares them
module mfuw_feedback_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [mfuw_pkg::FRAME_W-1:0] req_tdata,
   input  logic                         req_tuser,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [mfuw_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [mfuw_pkg::WD_W-1:0]    csr_data,
   output int                           pending,
   output int                           fail_count,
   output int                           expiry_count
);
   import mfuw_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic [SPD_W-1:0]   speed;
      logic [CUR_W-1:0]   current;
      logic [TEMP_W-1:0]  temperature;
      logic [TURN_W-1:0]  turns;
      logic [ANGLE_W-1:0] angle;
      logic               online;
      logic               expired;
   } feedback_type;

   feedback_type feedback_q[$];
   feedback_type oldest;

   logic [WD_W-1:0]    timeout_r;
   logic [POS_W-1:0]   last_pos_r;
   logic [SPD_W-1:0]   speed_r;
   logic [CUR_W-1:0]   current_r;
   logic [TEMP_W-1:0]  temp_r;
   logic [TURN_W-1:0]  turns_r;
   logic [ANGLE_W-1:0] angle_r;
   logic [WD_W-1:0]    watchdog_r;
   logic               online_r;

   int pending_n = 0;
   int fail_n    = 0;
   int expiry_n  = 0;

   assign pending      = pending_n;
   assign fail_count   = fail_n;
   assign expiry_count = expiry_n;

   // advances the motor state by one request and returns what the block should report
   function automatic feedback_type unwrap_feedback(input logic kind,
                                                    input logic [FRAME_W-1:0] frame);
      logic [POS_W-1:0]          pos;
      logic signed [DIFF_W-1:0]  delta;
      feedback_type              res;
      res = '0;
      if (kind == CMD_FRAME) begin
         pos   = frame[48 +: POS_W];
         delta = $signed({2'b00, pos}) - $signed({2'b00, last_pos_r});
         speed_r   = frame[47:32];
         current_r = frame[31:16];
         temp_r    = frame[15:8];
         // exactly half a turn is taken as a real move, not a wrap
         if (delta > HALF_TURN) begin
            delta   = delta - FULL_TURN;
            turns_r = turns_r - 1'b1;
         end else if (delta < -HALF_TURN) begin
            delta   = delta + FULL_TURN;
            turns_r = turns_r + 1'b1;
         end
         angle_r    = angle_r + {{(ANGLE_W-DIFF_W){delta[DIFF_W-1]}}, delta};
         last_pos_r = pos;
         watchdog_r = timeout_r;
         online_r   = 1'b1;
      end else if (online_r) begin
         // a zero timeout behaves like one
         if (watchdog_r <= 1) begin
            watchdog_r  = '0;
            speed_r     = '0;
            current_r   = '0;
            online_r    = 1'b0;
            res.expired = 1'b1;
            expiry_n++;
         end else begin
            watchdog_r = watchdog_r - 1'b1;
         end
      end
      res.position    = last_pos_r;
      res.speed       = speed_r;
      res.current     = current_r;
      res.temperature = temp_r;
      res.turns       = turns_r;
      res.angle       = angle_r;
      res.online      = online_r;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
         fail_n++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         timeout_r  = TIMEOUT_RESET;
         last_pos_r = '0;
         speed_r    = '0;
         current_r  = '0;
         temp_r     = '0;
         turns_r    = '0;
         angle_r    = '0;
         watchdog_r = TIMEOUT_RESET;
         online_r   = 1'b1;
         feedback_q.delete();
      end else begin
         // a new timeout only takes hold at the next frame's reload
         if (csr_valid && csr_ready)
            timeout_r = csr_data;
         if (req_tvalid && req_tready)
            feedback_q.push_back(unwrap_feedback(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (feedback_q.size() == 0) begin
               $display("%0t result with nothing expected: actual %0h", $time, rsp_tdata);
               fail_n++;
            end else begin
               oldest = feedback_q.pop_front();
               check_field("encoder_position", 64'(oldest.position),
                           64'(rsp_tdata[RSP_POS_LO +: POS_W]));
               check_field("speed_rpm", 64'(oldest.speed),
                           64'(rsp_tdata[RSP_SPD_LO +: SPD_W]));
               check_field("torque_current", 64'(oldest.current),
                           64'(rsp_tdata[RSP_CUR_LO +: CUR_W]));
               check_field("temperature", 64'(oldest.temperature),
                           64'(rsp_tdata[RSP_TEMP_LO +: TEMP_W]));
               check_field("turn_count", 64'(oldest.turns),
                           64'(rsp_tdata[RSP_TURN_LO +: TURN_W]));
               check_field("total_counts", 64'(oldest.angle),
                           64'(rsp_tdata[RSP_ANGLE_LO +: ANGLE_W]));
               check_field("online", 64'(oldest.online), 64'(rsp_tdata[RSP_ONLINE]));
               check_field("offline_event", 64'(oldest.expired), 64'(rsp_tdata[RSP_EVENT]));
            end
         end
      end
      pending_n = feedback_q.size();
   end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// testbench top: drives frames, ticks and timeout writes into the unwrap watchdog
module tb_top;
   import mfuw_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 64;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 150;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [FRAME_W-1:0] req_tdata  = '0;
   logic               req_tuser  = CMD_FRAME;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [WD_W-1:0]    csr_data   = '0;

   int pending;
   int fail_count;
   int expiry_count;

   int cycle_n    = 0;
   int frame_n    = 0;
   int tick_n     = 0;
   int settings_n = 0;

   logic             tx_idle   = 1'b1;
   logic             rx_idle   = 1'b1;
   logic             long_hold = 1'b0;
   logic [POS_W-1:0] last_pos  = '0;

   motor_feedback_unwrap_watchdog i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   mfuw_feedback_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .pending      (pending),
      .fail_count   (fail_count),
      .expiry_count (expiry_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
      if (cycle_n >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_n, pending);
         $display("FAIL motor_feedback_unwrap_watchdog");
         $finish;
      end
   end

   // result side: random stalls per result, plus one long hold-off on request
   initial begin : rsp_side
      int unsigned hold;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            hold = rx_idle ? $urandom_range(0, 15) : 0;
            if (hold != 0) begin
               rsp_tready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic send_request(input logic kind, input logic [FRAME_W-1:0] data);
      int unsigned gap;
      gap = tx_idle ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      if (kind == CMD_FRAME) begin
         last_pos = data[48 +: POS_W];
         frame_n++;
      end else begin
         tick_n++;
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [WD_W-1:0] ticks);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= ticks;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      settings_n++;
   endtask

   // position word for the next frame, biased toward seams and the half-turn threshold
   function automatic logic [15:0] pick_position();
      logic [POS_W-1:0] pos;
      case ($urandom_range(0, 9))
         0, 1: pos = POS_W'($urandom);
         2, 3: pos = last_pos + POS_W'($urandom_range(0, 200)) - POS_W'(100);
         4:    pos = last_pos + POS_W'(4096);
         5:    pos = last_pos + POS_W'($urandom_range(4090, 4102));
         6:    pos = $urandom_range(0, 1) ? POS_W'($urandom_range(8100, 8191))
                                          : POS_W'($urandom_range(0, 90));
         default: pos = last_pos + POS_W'($urandom_range(0, 2000));
      endcase
      return {3'($urandom), pos};
   endfunction

   initial begin : stimulus
      logic [WD_W-1:0] phase_timeout [PHASES];
      int unsigned     tick_pct;

      phase_timeout[0] = 16'd1;
      phase_timeout[1] = 16'hFFFF;
      phase_timeout[2] = WD_W'($urandom_range(2, 40));
      phase_timeout[3] = TIMEOUT_RESET;
      phase_timeout[4] = WD_W'($urandom_range(1, 12));
      phase_timeout[5] = WD_W'($urandom_range(1, 65535));
      phase_timeout[6] = 16'd5;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset timeout: half-turn steps, wraps both ways, field extremes
      send_request(CMD_TICK, '1);
      send_request(CMD_FRAME, 64'h1000_7FFF_8000_55AA);
      send_request(CMD_FRAME, 64'h0000_8000_7FFF_FF00);
      send_request(CMD_FRAME, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(CMD_FRAME, 64'hE000_0000_0000_0000);
      send_request(CMD_FRAME, 64'h1001_0001_FFFF_0112);
      send_request(CMD_FRAME, 64'h0000_FFFF_0001_8034);
      send_request(CMD_TICK, '0);

      // zero timeout expires on the first tick
      write_timeout(16'd0);
      send_request(CMD_FRAME, 64'h0123_4567_89AB_CDEF);
      send_request(CMD_TICK, '0);
      send_request(CMD_TICK, '1);
      send_request(CMD_FRAME, 64'h1FFF_0102_0304_0506);
      send_request(CMD_TICK, '0);

      write_timeout(16'd2);
      send_request(CMD_TICK, '0);
      send_request(CMD_FRAME, 64'h0FFF_1234_EDCB_7700);
      send_request(CMD_TICK, '0);
      send_request(CMD_TICK, '0);
      send_request(CMD_FRAME, 64'h1800_4000_C000_2200);

      // new timeout does not touch the running count
      write_timeout(16'hFFFF);
      send_request(CMD_TICK, '0);
      send_request(CMD_TICK, '0);
      send_request(CMD_FRAME, 64'h0400_0010_FFF0_3300);
      send_request(CMD_TICK, '0);

      for (int ph = 0; ph < PHASES; ph++) begin
         write_timeout(phase_timeout[ph]);
         tick_pct = $urandom_range(10, 70);
         tx_idle  = $urandom_range(0, 3) != 0;
         rx_idle  = $urandom_range(0, 3) != 0;
         if (ph == 3) begin
            // back-to-back requests against a stalled result side
            tx_idle   = 1'b0;
            rx_idle   = 1'b0;
            long_hold = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 50 == 49) begin
               tx_idle = $urandom_range(0, 1) != 0;
               rx_idle = $urandom_range(0, 1) != 0;
            end
            if ($urandom_range(0, 99) < tick_pct)
               send_request(CMD_TICK, {$urandom, $urandom});
            else
               send_request(CMD_FRAME, {pick_position(), 16'($urandom), 16'($urandom),
                                        16'($urandom)});
         end
      end

      settle();
      repeat (8) @(posedge clock);

      $display("sent %0d feedback frames and %0d ticks across %0d timeout settings",
               frame_n, tick_n, settings_n);
      $display("watchdog expired %0d times, %0d mismatches", expiry_count, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS motor_feedback_unwrap_watchdog");
      end else begin
         $display("FAIL motor_feedback_unwrap_watchdog");
      end
      $finish;
   end

endmodule

@@ motor_feedback_unwrap_watchdog.f @@
+incdir+hdl
hdl/mfuw_pkg.sv
hdl/mfuw_step.sv
hdl/motor_feedback_unwrap_watchdog.sv
test/mfuw_feedback_checker.sv
test/tb_top.sv
